// File: hdl/lr_pkg.sv
package lr_pkg;

    localparam int COORD_BITS_DEF = 6;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic
    {
        LR_IDLE,
        LR_RUN
    } lr_state_t;

endpackage

// File: hdl/line_rasterizer_unit.sv
// Channel  Direction  Handshake            Payload
// segment  in         in_valid / in_stall  start_x start_y end_x end_y
// pixel    out        out_valid / out_stall pixel_x pixel_y last_pixel
//
// A segment with major delta M gives M+1 pixel beats, one per cycle at the stepper unless out_stall holds it.
// The stepper loads each segment in its IDLE state and then steps it in its RUN state.
// The front classifies a segment into its front register and a two-entry queue holds pending segments.
// Reset clears the queue, the front register valid, the stepper state and out_valid; nothing else.
// out_stall holds the pixel register and the stepper; in_stall rises when front and queue fill.
module line_rasterizer_unit #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  last_pixel
);

    localparam int CMD_W = 3 + 4 * COORD_BITS;

    logic             push;
    logic             q_full;
    logic             q_empty;
    logic             pop;
    logic [CMD_W-1:0] push_data;
    logic [CMD_W-1:0] pop_data;

    lr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .push      (push),
        .q_full    (q_full),
        .push_data (push_data)
    );

    lr_queue #(
        .WIDTH (CMD_W),
        .DEPTH (lr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .pop_data  (pop_data)
    );

    lr_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .pop_data   (pop_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

endmodule

// File: hdl/lr_front.sv
module lr_front #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF,
    localparam int CMD_W = 3 + 4 * COORD_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic                  push,
    input  logic                  q_full,
    output logic [CMD_W-1:0]      push_data
);

    typedef struct packed {
        logic                  ymajor;
        logic                  maj_neg;
        logic                  min_neg;
        logic [COORD_BITS-1:0] maj0;
        logic [COORD_BITS-1:0] min0;
        logic [COORD_BITS-1:0] major;
        logic [COORD_BITS-1:0] minor;
    } cmd_t;

    cmd_t                  cmd_reg;
    cmd_t                  cmd_next;
    logic                  cmd_valid_reg;
    logic                  cmd_valid_next;
    logic                  load;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic                  x_neg;
    logic                  y_neg;
    logic                  ymajor;

    assign push     = cmd_valid_reg && !q_full;
    assign in_stall = cmd_valid_reg && q_full;
    assign load     = in_valid && !in_stall;
    assign push_data = cmd_reg;

    always_comb
    begin
        x_neg  = end_x < start_x;
        y_neg  = end_y < start_y;
        adx    = x_neg ? start_x - end_x : end_x - start_x;
        ady    = y_neg ? start_y - end_y : end_y - start_y;
        ymajor = adx < ady;
        cmd_next.ymajor  = ymajor;
        cmd_next.maj_neg = ymajor ? y_neg : x_neg;
        cmd_next.min_neg = ymajor ? x_neg : y_neg;
        cmd_next.maj0    = ymajor ? start_y : start_x;
        cmd_next.min0    = ymajor ? start_x : start_y;
        cmd_next.major   = ymajor ? ady : adx;
        cmd_next.minor   = ymajor ? adx : ady;
    end

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (load)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (push)
        begin
            cmd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// File: hdl/lr_queue.sv
module lr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lr_pkg::QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full     = cnt_reg == FULL_CNT;
    assign empty    = cnt_reg == '0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/lr_stepper.sv
module lr_stepper #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF,
    localparam int CMD_W = 3 + 4 * COORD_BITS,
    localparam int ERR_W = COORD_BITS + 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  logic [CMD_W-1:0]      pop_data,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  last_pixel
);

    typedef struct packed {
        logic                  ymajor;
        logic                  maj_neg;
        logic                  min_neg;
        logic [COORD_BITS-1:0] maj0;
        logic [COORD_BITS-1:0] min0;
        logic [COORD_BITS-1:0] major;
        logic [COORD_BITS-1:0] minor;
    } cmd_t;

    cmd_t                     cmd;
    lr_pkg::lr_state_t        state_reg;
    lr_pkg::lr_state_t        state_next;
    logic                     emit;
    logic                     done;
    logic                     ymajor_reg;
    logic                     maj_neg_reg;
    logic                     min_neg_reg;
    logic [COORD_BITS-1:0]    mj_reg;
    logic [COORD_BITS-1:0]    mj_next;
    logic [COORD_BITS-1:0]    mn_reg;
    logic [COORD_BITS-1:0]    mn_next;
    logic [COORD_BITS-1:0]    rem_reg;
    logic [COORD_BITS-1:0]    rem_next;
    logic [COORD_BITS:0]      major2_reg;
    logic [COORD_BITS:0]      minor2_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [ERR_W-1:0]  err_next;
    logic signed [ERR_W-1:0]  err_add;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [COORD_BITS-1:0]    pixel_x_reg;
    logic [COORD_BITS-1:0]    pixel_y_reg;
    logic                     last_reg;

    assign cmd        = cmd_t'(pop_data);
    assign out_valid  = out_valid_reg;
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign last_pixel = last_reg;
    assign done       = rem_reg == '0;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lr_pkg::LR_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = lr_pkg::LR_RUN;
                end
            end
            lr_pkg::LR_RUN:
            begin
                if (emit && done)
                begin
                    state_next = lr_pkg::LR_IDLE;
                end
            end
            default:
            begin
                state_next = lr_pkg::LR_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop  = 1'b0;
        emit = 1'b0;
        case (state_reg)
            lr_pkg::LR_IDLE:
            begin
                pop = !q_empty;
            end
            lr_pkg::LR_RUN:
            begin
                emit = !out_valid_reg || !out_stall;
            end
            default:
            begin
                pop  = 1'b0;
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        err_add  = err_reg + $signed({2'b00, minor2_reg});
        mj_next  = maj_neg_reg ? mj_reg - 1'b1 : mj_reg + 1'b1;
        mn_next  = mn_reg;
        err_next = err_add;
        rem_next = rem_reg - 1'b1;
        if (err_add > 0)
        begin
            err_next = err_add - $signed({2'b00, major2_reg});
            mn_next  = min_neg_reg ? mn_reg - 1'b1 : mn_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lr_pkg::LR_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ymajor_reg  <= cmd.ymajor;
            maj_neg_reg <= cmd.maj_neg;
            min_neg_reg <= cmd.min_neg;
            mj_reg      <= cmd.maj0;
            mn_reg      <= cmd.min0;
            rem_reg     <= cmd.major;
            major2_reg  <= {cmd.major, 1'b0};
            minor2_reg  <= {cmd.minor, 1'b0};
            err_reg     <= -$signed({3'b000, cmd.major});
        end
        else if (emit && !done)
        begin
            mj_reg  <= mj_next;
            mn_reg  <= mn_next;
            err_reg <= err_next;
            rem_reg <= rem_next;
        end
        if (emit)
        begin
            pixel_x_reg <= ymajor_reg ? mn_reg : mj_reg;
            pixel_y_reg <= ymajor_reg ? mj_reg : mn_reg;
            last_reg    <= done;
        end
    end

endmodule

// File: hdl/lr_checker.sv
module lr_checker #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic [COORD_BITS-1:0] start_x,
    input logic [COORD_BITS-1:0] start_y,
    input logic [COORD_BITS-1:0] end_x,
    input logic [COORD_BITS-1:0] end_y,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [COORD_BITS-1:0] pixel_x,
    input logic [COORD_BITS-1:0] pixel_y,
    input logic                  last_pixel
);

    localparam logic [COORD_BITS-1:0] ONE     = COORD_BITS'(1);
    localparam logic [COORD_BITS-1:0] MINUS   = '1;
    localparam logic [COORD_BITS:0]   MAX_IDX = (COORD_BITS + 1)'((1 << COORD_BITS) - 1);

    logic                  out_beat;
    logic                  mid_reg;
    logic [COORD_BITS-1:0] prev_x_reg;
    logic [COORD_BITS-1:0] prev_y_reg;
    logic [COORD_BITS:0]   idx_reg;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic                  dx_ok;
    logic                  dy_ok;

    assign out_beat = out_valid && !out_stall;
    assign dx    = pixel_x - prev_x_reg;
    assign dy    = pixel_y - prev_y_reg;
    assign dx_ok = (dx == '0) || (dx == ONE) || (dx == MINUS);
    assign dy_ok = (dy == '0) || (dy == ONE) || (dy == MINUS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg    <= 1'b0;
            idx_reg    <= '0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
        end
        else if (out_beat)
        begin
            mid_reg    <= !last_pixel;
            idx_reg    <= last_pixel ? '0 : idx_reg + 1'b1;
            prev_x_reg <= pixel_x;
            prev_y_reg <= pixel_y;
        end
    end

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(start_x) && $stable(start_y)
            && $stable(end_x) && $stable(end_y))
        else $error("segment beat changed under stall");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
            && $stable(last_pixel))
        else $error("pixel beat changed under stall");

    a_neighbor: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && mid_reg |-> dx_ok && dy_ok && ((dx != '0) || (dy != '0)))
        else $error("pixel not adjacent to the previous pixel of the segment");

    a_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> idx_reg <= MAX_IDX)
        else $error("segment longer than the coordinate range");

    a_end_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && (idx_reg == MAX_IDX) |-> last_pixel)
        else $error("full-length segment missing its last pixel flag");

endmodule

bind line_rasterizer_unit lr_checker #(
    .COORD_BITS (COORD_BITS)
) u_lr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (last_pixel)
);

// File: bench/tb_line_rasterizer_unit.sv
module tb_line_rasterizer_unit;

    localparam int CB          = lr_pkg::COORD_BITS_DEF;
    localparam int COORD_MAX   = (1 << CB) - 1;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TAIL_CYCLES = 100;
    localparam int HOLD_CYCLES = 600;
    localparam int PHASE_ITEMS = 93;

    typedef logic [CB-1:0] coord_t;

    typedef struct packed
    {
        coord_t x;
        coord_t y;
        logic   last;
    } pixel_t;

    class pixel_scoreboard;
        pixel_t expected_pixels[$];
        int     mismatches;

        function void note_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
            int     x0, y0, x1, y1;
            int     adx, ady, major, minor;
            int     maj0, min0, maj1, min1;
            int     dmaj, dmin, err, mn, mj, i;
            bit     ymajor;
            pixel_t p;
            x0 = sx;
            y0 = sy;
            x1 = ex;
            y1 = ey;
            adx = (x1 >= x0) ? x1 - x0 : x0 - x1;
            ady = (y1 >= y0) ? y1 - y0 : y0 - y1;
            ymajor = adx < ady;
            maj0 = ymajor ? y0 : x0;
            min0 = ymajor ? x0 : y0;
            maj1 = ymajor ? y1 : x1;
            min1 = ymajor ? x1 : y1;
            major = ymajor ? ady : adx;
            minor = ymajor ? adx : ady;
            dmaj = (maj1 < maj0) ? -1 : 1;
            dmin = (min1 < min0) ? -1 : 1;
            err = -major;
            mn = min0;
            for (i = 0; i <= major; i++)
            begin
                mj = maj0 + i * dmaj;
                if (i > 0)
                begin
                    err += 2 * minor;
                    if (err > 0)
                    begin
                        err -= 2 * major;
                        mn += dmin;
                    end
                end
                p.x = coord_t'(ymajor ? mn : mj);
                p.y = coord_t'(ymajor ? mj : mn);
                p.last = (i == major);
                expected_pixels.push_back(p);
            end
        endfunction

        function void check_pixel(coord_t x, coord_t y, logic last);
            pixel_t p;
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel beat: x=%0d y=%0d last=%0b", x, y, last);
                return;
            end
            p = expected_pixels.pop_front();
            if (p.x !== x || p.y !== y || p.last !== last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pixel mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                             p.x, p.y, p.last, x, y, last);
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    logic   out_valid;
    logic   out_stall;
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;

    pixel_scoreboard sb = new();

    int send_idle_pct;
    int stall_pct;
    bit hold_request;
    int cycle_count;

    int directed_segs [18][4] = '{
        '{ 0,  0,  0,  0},
        '{63, 63, 63, 63},
        '{ 0,  0, 63,  0},
        '{63,  0,  0,  0},
        '{ 0,  0,  0, 63},
        '{ 0, 63,  0,  0},
        '{ 0,  0, 63, 63},
        '{63,  0,  0, 63},
        '{ 0, 63, 63,  0},
        '{63, 63,  0,  0},
        '{ 5,  5,  9,  7},
        '{ 9,  7,  5,  5},
        '{ 3, 10,  6,  2},
        '{ 0,  0, 63, 62},
        '{62,  0,  0, 63},
        '{10, 20, 11, 20},
        '{21, 42, 42, 21},
        '{42, 21, 21, 42}
    };

    line_rasterizer_unit #(
        .COORD_BITS(CB)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .last_pixel(last_pixel)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_segment(start_x, start_y, end_x, end_y);
            if (out_valid && !out_stall)
                sb.check_pixel(pixel_x, pixel_y, last_pixel);
        end
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
                out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_segment(input int sx, input int sy, input int ex, input int ey);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        start_x = coord_t'(sx);
        start_y = coord_t'(sy);
        end_x = coord_t'(ex);
        end_y = coord_t'(ey);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic int near_coord(int c);
        int n;
        n = c + int'($urandom_range(6)) - 3;
        if (n < 0)
            n = 0;
        if (n > COORD_MAX)
            n = COORD_MAX;
        return n;
    endfunction

    task automatic pick_segment(output int sx, output int sy, output int ex, output int ey);
        sx = $urandom_range(COORD_MAX);
        sy = $urandom_range(COORD_MAX);
        if ($urandom_range(3) == 0)
        begin
            ex = near_coord(sx);
            ey = near_coord(sy);
        end
        else
        begin
            ex = $urandom_range(COORD_MAX);
            ey = $urandom_range(COORD_MAX);
        end
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int items, input int idle_pct, input int stall_rate,
                             input bit with_hold);
        int sx, sy, ex, ey, k;
        send_idle_pct = idle_pct;
        stall_pct = stall_rate;
        for (k = 0; k < items; k++)
        begin
            if (with_hold && k == 5)
                hold_request = 1'b1;
            pick_segment(sx, sy, ex, ey);
            send_segment(sx, sy, ex, ey);
        end
        drain();
    endtask

    initial
    begin
        int k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_request = 1'b0;
        cycle_count = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (k = 0; k < 18; k++)
            send_segment(directed_segs[k][0], directed_segs[k][1],
                         directed_segs[k][2], directed_segs[k][3]);
        drain();

        run_phase(PHASE_ITEMS, 0, 0, 1'b0);
        run_phase(PHASE_ITEMS, 88, 0, 1'b0);
        run_phase(PHASE_ITEMS, 0, 88, 1'b0);
        run_phase(PHASE_ITEMS, 38, 38, 1'b0);
        run_phase(PHASE_ITEMS, 0, 0, 1'b1);

        stall_pct = 0;
        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
